### rtl/core/smdg_pkg.sv
// Shared constants for the signed division magic number generator.
package smdg_pkg;

  localparam int WORD_BITS_DEF = 32;
  localparam int DIVISOR_W     = 32;
  localparam int MAGIC_W       = 32;
  localparam int SHIFT_W       = 5;

endpackage

### rtl/core/smdg_in_if.sv
// Divisor channel: valid/ready handshake with one signed divisor per beat.
interface smdg_in_if;
  import smdg_pkg::*;

  logic                        valid;
  logic                        ready;
  logic signed [DIVISOR_W-1:0] divisor;

  modport source (output valid, output divisor, input ready);
  modport sink   (input valid, input divisor, output ready);

endinterface

### rtl/core/smdg_out_if.sv
// Result channel: valid/ready handshake with magic, shift and invalid flag per beat.
interface smdg_out_if;
  import smdg_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [MAGIC_W-1:0] magic;
  logic        [SHIFT_W-1:0] shift;
  logic                      invalid;

  modport source (output valid, output magic, output shift, output invalid, input ready);
  modport sink   (input valid, input magic, input shift, input invalid, output ready);

endinterface

### rtl/core/signed_magic_divisor_generator.sv
// Top level of the signed division magic number generator.
// Usage:
//   in_chan  (sink): one signed 32-bit divisor per beat.
//   out_chan (source): magic multiplier, shift and invalid flag, one beat per divisor.
//   The divisor is taken modulo 2^WORD_BITS; divisors -1, 0 and 1 give invalid = 1
//   with magic and shift zero.
// Sequence: one restoring division of 2^(W-1) by |d|, a fix-up step, a second
//   division by the anchor value, then refinement steps (two passes through the
//   single shift-subtract unit and a test each); the result is then registered.
//   The single shift-subtract unit serves all of these steps.
// Throughput: one divisor at a time; in_chan.ready is high only while idle.
// Reset: rst_n (synchronous, active low) returns the sequencer to idle and drops
//   out_chan.valid.
// Stall: a finished result is held in the output register until taken; a new
//   divisor may be accepted meanwhile, and its result waits for the register.
module signed_magic_divisor_generator #(
  parameter int WORD_BITS = smdg_pkg::WORD_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  smdg_in_if.sink    in_chan,
  smdg_out_if.source out_chan
);
  import smdg_pkg::*;

  localparam int W     = WORD_BITS;
  localparam int CNT_W = $clog2(2 * W + 1);
  localparam logic [W-1:0] TOP  = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] ONES = {W{1'b1}};

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DIV2  = 3'd1;
  localparam logic [2:0] S_FIX   = 3'd2;
  localparam logic [2:0] S_DIV1  = 3'd3;
  localparam logic [2:0] S_LOOP1 = 3'd4;
  localparam logic [2:0] S_LOOP2 = 3'd5;
  localparam logic [2:0] S_TEST  = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] steps_r, steps_nxt;
  logic [W-1:0]     ad_r, ad_nxt;
  logic [W-1:0]     anc_r, anc_nxt;
  logic [W-1:0]     q1_r, q1_nxt, r1_r, r1_nxt;
  logic [W-1:0]     q2_r, q2_nxt, r2_r, r2_nxt;
  logic             neg_r, neg_nxt;
  logic             inv_r, inv_nxt;

  logic                      out_valid_r;
  logic signed [MAGIC_W-1:0] magic_r;
  logic        [SHIFT_W-1:0] shift_r;
  logic                      invalid_r;

  logic [W-1:0] d_w, ad_in;
  logic         in_fire, load;

  logic         sel_one, u_bit;
  logic [W-1:0] u_rem, u_quo, u_dvs, u_rem_out, u_quo_out;

  logic [W-1:0] rsum, rmod, anc_calc, delta;
  logic         keep_going;
  logic signed [W-1:0] m_s;

  // ---- input decode
  assign d_w     = W'(in_chan.divisor);
  assign ad_in   = d_w[W-1] ? (~d_w + W'(1)) : d_w;
  assign in_chan.ready = (state_r == S_IDLE);
  assign in_fire = in_chan.valid && in_chan.ready;

  // ---- shared unit
  assign sel_one = (state_r == S_DIV1) || (state_r == S_LOOP1);
  assign u_rem   = sel_one ? r1_r : r2_r;
  assign u_quo   = sel_one ? q1_r : q2_r;
  assign u_dvs   = sel_one ? anc_r : ad_r;
  assign u_bit   = ((state_r == S_DIV1) || (state_r == S_DIV2)) && (cnt_r == '0);

  smdg_divstep #(.W(W)) u_step (
    .rem_in  (u_rem),
    .quo_in  (u_quo),
    .dvs     (u_dvs),
    .bit_in  (u_bit),
    .rem_out (u_rem_out),
    .quo_out (u_quo_out)
  );

  // ---- fix-up and loop test
  assign rsum     = r2_r + W'(neg_r);
  assign rmod     = (rsum == ad_r) ? '0 : rsum;
  assign anc_calc = TOP + W'(neg_r) - W'(1) - rmod;
  assign delta    = ad_r - r2_r;
  assign keep_going = ((q1_r < delta) || ((q1_r == delta) && (r1_r == '0)))
                      && (steps_r < CNT_W'(2 * W));

  assign m_s  = neg_r ? ~q2_r : (q2_r + W'(1));
  assign load = (state_r == S_DONE) && (!out_valid_r || out_chan.ready);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    steps_nxt = steps_r;
    ad_nxt    = ad_r;
    anc_nxt   = anc_r;
    q1_nxt    = q1_r;
    r1_nxt    = r1_r;
    q2_nxt    = q2_r;
    r2_nxt    = r2_r;
    neg_nxt   = neg_r;
    inv_nxt   = inv_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          neg_nxt = d_w[W-1];
          ad_nxt  = ad_in;
          inv_nxt = (d_w == '0) || (d_w == W'(1)) || (d_w == ONES);
          q2_nxt  = '0;
          r2_nxt  = '0;
          cnt_nxt = '0;
          steps_nxt = '0;
          state_nxt = inv_nxt ? S_DONE : S_DIV2;
        end
      end
      S_DIV2: begin
        q2_nxt  = u_quo_out;
        r2_nxt  = u_rem_out;
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(W - 1)) state_nxt = S_FIX;
      end
      S_FIX: begin
        anc_nxt = (anc_calc == '0) ? W'(1) : anc_calc;
        q1_nxt  = '0;
        r1_nxt  = '0;
        cnt_nxt = '0;
        state_nxt = S_DIV1;
      end
      S_DIV1: begin
        q1_nxt  = u_quo_out;
        r1_nxt  = u_rem_out;
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(W - 1)) begin
          steps_nxt = '0;
          state_nxt = S_LOOP1;
        end
      end
      S_LOOP1: begin
        q1_nxt    = u_quo_out;
        r1_nxt    = u_rem_out;
        state_nxt = S_LOOP2;
      end
      S_LOOP2: begin
        q2_nxt    = u_quo_out;
        r2_nxt    = u_rem_out;
        steps_nxt = steps_r + CNT_W'(1);
        state_nxt = S_TEST;
      end
      S_TEST: begin
        state_nxt = keep_going ? S_LOOP1 : S_DONE;
      end
      S_DONE: begin
        if (load) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cnt_r   <= cnt_nxt;
    steps_r <= steps_nxt;
    ad_r    <= ad_nxt;
    anc_r   <= anc_nxt;
    q1_r    <= q1_nxt;
    r1_r    <= r1_nxt;
    q2_r    <= q2_nxt;
    r2_r    <= r2_nxt;
    neg_r   <= neg_nxt;
    inv_r   <= inv_nxt;
    if (load) begin
      magic_r   <= inv_r ? '0 : MAGIC_W'(m_s);
      shift_r   <= inv_r ? '0 : SHIFT_W'(steps_r - CNT_W'(1));
      invalid_r <= inv_r;
    end
  end

  assign out_chan.valid   = out_valid_r;
  assign out_chan.magic   = magic_r;
  assign out_chan.shift   = shift_r;
  assign out_chan.invalid = invalid_r;

endmodule

### rtl/core/smdg_divstep.sv
// Shared shift-compare-subtract step used by both divisions and the refinement loop.
module smdg_divstep #(
  parameter int W = smdg_pkg::WORD_BITS_DEF
) (
  input  logic [W-1:0] rem_in,
  input  logic [W-1:0] quo_in,
  input  logic [W-1:0] dvs,
  input  logic         bit_in,
  output logic [W-1:0] rem_out,
  output logic [W-1:0] quo_out
);
  import smdg_pkg::*;

  logic [W-1:0] shifted;
  logic         ge;

  // remainder stays below the divisor (at most half range), so the shift never overflows
  assign shifted = {rem_in[W-2:0], bit_in};
  assign ge      = (shifted >= dvs);
  assign rem_out = ge ? (shifted - dvs) : shifted;
  assign quo_out = {quo_in[W-2:0], ge};

endmodule
